// File: rtl/core/txtcon_pkg.sv
// Shared constants, codes and control types of the text console writer.
`timescale 1ns / 1ps

package txtcon_pkg;

  // Screen geometry
  localparam int ROW_COUNT  = 25;
  localparam int COL_COUNT  = 80;
  localparam int CELL_TOTAL = ROW_COUNT * COL_COUNT;

  // Field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ADDR_W = $clog2(CELL_TOTAL);

  // Stream payload widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COL_COUNT - 1);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0d;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

  // Item kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_PUSH
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // take the input item and do its work
    logic read_done;  // capture the cell read from the screen store
    logic clr_step;   // write one cell of the clearing sweep
    logic push;       // move the pending result into the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;   // the offered item is a cell read
    logic scroll;    // the offered put scrolls the screen
    logic clr_last;  // the sweep is at its last cell
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

  // Result item, laid out as on out_tdata (lowest field in the lowest bits)
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] cell_value;
    logic              counted;
  } result_t;

endpackage

// File: rtl/core/txtcon_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps

module txtcon_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/txtcon_ctrl.sv
// Controller state machine: sequences clearing sweeps, reads and result transfers.
`timescale 1ns / 1ps

module txtcon_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  txtcon_pkg::dp_stat_t  stat,
  output txtcon_pkg::ctl_cmd_t  cmd
);

  import txtcon_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // State register; reset starts the sweep that clears the screen store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          priority if (stat.is_read) begin
            state_nxt = ST_READ;
          end else if (stat.scroll) begin
            state_nxt = ST_SCROLL;
          end else begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_READ: begin
        cmd.read_done = 1'b1;
        state_nxt     = ST_PUSH;
      end
      ST_SCROLL: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

// File: rtl/core/txtcon_dp.sv
// Datapath: cursor, scroll base, screen store, clearing sweep and result registers.
`timescale 1ns / 1ps

module txtcon_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [txtcon_pkg::ATTR_W-1:0]         cfg_wdata,
  input  logic                                  in_tuser,
  input  logic [txtcon_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [txtcon_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  txtcon_pkg::ctl_cmd_t                  cmd,
  output txtcon_pkg::dp_stat_t                  stat
);

  import txtcon_pkg::*;

  // Screen row r lives in physical row (base + r) mod ROW_COUNT
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] base,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W:0] sum;
    sum = {1'b0, base} + {1'b0, row};
    if (sum >= (ROW_W+1)'(ROW_COUNT)) begin
      sum = sum - (ROW_W+1)'(ROW_COUNT);
    end
    return ADDR_W'(sum) * ADDR_W'(COL_COUNT) + ADDR_W'(col);
  endfunction

  // Input fields
  logic              in_kind;
  logic [CHAR_W-1:0] in_char;
  logic [ROW_W-1:0]  in_rrow;
  logic [COL_W-1:0]  in_rcol;

  assign in_kind = in_tuser;
  assign in_char = in_tdata[7:0];
  assign in_rrow = in_tdata[12:8];
  assign in_rcol = in_tdata[19:13];

  // State
  logic [ATTR_W-1:0] attr_r;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  base_r, base_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_end_r;
  logic [CELL_W-1:0] clr_data_r;
  logic              rd_ok_r;
  result_t           res_r;
  result_t           out_r;
  logic              out_valid_r;

  // Decode of the offered item
  logic              is_put_char;
  logic              advance;
  logic              scroll;
  logic              rd_ok;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] put_addr;
  logic [ADDR_W-1:0] row_start;
  logic [CELL_W-1:0] ram_rdata;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;

  always_comb begin
    is_put_char = (in_kind == KIND_PUT) && (in_char != CH_NEWLINE) &&
                  (in_char != CH_RETURN);
    advance     = (in_kind == KIND_PUT) &&
                  ((in_char == CH_NEWLINE) || (is_put_char && (cur_col_r == COL_LAST)));
    scroll      = advance && (cur_row_r == ROW_LAST);

    // Cursor after the item
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (advance) begin
      cur_col_nxt = '0;
      if (!scroll) begin
        cur_row_nxt = cur_row_r + 1'b1;
      end
    end else if (is_put_char) begin
      cur_col_nxt = cur_col_r + 1'b1;
    end

    // A scroll makes the old top physical row the new bottom row
    base_nxt = base_r;
    if (scroll) begin
      base_nxt = (base_r == ROW_LAST) ? '0 : base_r + 1'b1;
    end

    rd_ok     = (in_rrow < ROW_W'(ROW_COUNT)) && (in_rcol < COL_W'(COL_COUNT));
    rd_addr   = rd_ok ? cell_addr(base_r, in_rrow, in_rcol) : '0;
    put_addr  = cell_addr(base_r, cur_row_r, cur_col_r);
    row_start = ADDR_W'(base_r) * ADDR_W'(COL_COUNT);

    // Write port: sweep cells or the put character
    ram_we    = (cmd.accept && is_put_char) || cmd.clr_step;
    ram_waddr = cmd.clr_step ? clr_addr_r : put_addr;
    ram_wdata = cmd.clr_step ? clr_data_r : {attr_r, in_char};
  end

  txtcon_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_TOTAL)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Control state: attribute, cursor, base, sweep bounds, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RESET;
      cur_row_r   <= ROW_LAST;
      cur_col_r   <= '0;
      base_r      <= '0;
      clr_addr_r  <= '0;
      clr_end_r   <= ADDR_W'(CELL_TOTAL - 1);
      clr_data_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        cur_row_r <= cur_row_nxt;
        cur_col_r <= cur_col_nxt;
        base_r    <= base_nxt;
        if (scroll) begin
          clr_addr_r <= row_start;
          clr_end_r  <= row_start + ADDR_W'(COL_COUNT - 1);
          clr_data_r <= {attr_r, {CHAR_W{1'b0}}};
        end
      end else if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: pending result and output register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_r.counted    <= (in_kind == KIND_PUT) && (in_char != CH_RETURN);
      res_r.cell_value <= '0;
      res_r.row        <= cur_row_nxt;
      res_r.col        <= cur_col_nxt;
      rd_ok_r          <= rd_ok;
    end else if (cmd.read_done) begin
      res_r.cell_value <= rd_ok_r ? ram_rdata : '0;
    end
    if (cmd.push) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_r);

  always_comb begin
    stat.is_read  = (in_kind == KIND_READ);
    stat.scroll   = scroll;
    stat.clr_last = (clr_addr_r == clr_end_r);
    stat.out_free = !out_valid_r || out_tready;
  end

  // Checks
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_col_r < COL_W'(COL_COUNT))
    else $error("cursor column beyond last column");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_row_r < ROW_W'(ROW_COUNT))
    else $error("cursor row beyond last row");

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    base_r < ROW_W'(ROW_COUNT))
    else $error("scroll base beyond last row");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> (clr_addr_r <= clr_end_r))
    else $error("clearing sweep ran past its end");

  a_no_push_over: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.push)
    else $error("result pushed over an untaken result");

endmodule

// File: rtl/core/text_console_writer_core.sv
// Top level of the text console writer: controller and datapath.
//
// Channel  Direction  Handshake           Payload
// in_      slave      in_tvalid/tready    tdata char_code, read_row, read_col; tuser kind
// out_     master     out_tvalid/tready   tdata counted, cell_value, cursor_row, cursor_col
// cfg_     write      cfg_we              cfg_wdata text_attribute
//
// A read takes its cell from the registered screen store read.
// A put that scrolls also clears the new bottom row of COL_COUNT (80) cells.
// After reset the store is cleared one cell a cycle, all CELL_TOTAL (2000) cells,
// before the first item is taken; configuration writes are taken throughout.
// One item is worked at a time; the next is taken while a result waits in the
// output register, and work holds when that register is still occupied.
`timescale 1ns / 1ps

module text_console_writer_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [txtcon_pkg::ATTR_W-1:0]         cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
  input  logic [txtcon_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] kind
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] counted, [16:1] cell_value, [21:17] cursor_row, [28:22] cursor_col, [31:29] zero
  output logic [txtcon_pkg::OUT_DATA_W-1:0]     out_tdata
);

  import txtcon_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  txtcon_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  txtcon_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
